// ===== rtl/core/rsci_pkg.sv =====
`timescale 1ns / 1ps
// shared types, character codes and response text functions of the command interpreter
package rsci_pkg;

    typedef logic [7:0] byte_t;

    localparam int LINE_DEPTH = 8;
    localparam int LINE_IDX_W = $clog2(LINE_DEPTH);
    localparam int COUNT_W    = 4;
    localparam int POS_W      = 5;
    localparam int FREQ_DIGITS = 6;
    localparam int FREQ_W     = 4 * FREQ_DIGITS;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
    localparam logic [COUNT_W-1:0] MIN_CMD_LEN = 4'd2;
    localparam logic [COUNT_W-1:0] LINE_DEPTH_CNT = COUNT_W'(LINE_DEPTH);
    localparam logic [COUNT_W-1:0] FIRST_ARG_POS  = 4'd2;

    // frequency held as six bcd digits, reset 16000 khz
    localparam logic [FREQ_W-1:0] FREQ_RESET_BCD = 24'h016000;

    localparam byte_t CHAR_SEMI = 8'h3B;
    localparam byte_t CHAR_0    = 8'h30;
    localparam byte_t CHAR_1    = 8'h31;
    localparam byte_t CHAR_9    = 8'h39;
    localparam byte_t CHAR_T    = 8'h54;
    localparam byte_t CHAR_X    = 8'h58;
    localparam byte_t CHAR_F    = 8'h46;
    localparam byte_t CHAR_A    = 8'h41;
    localparam byte_t CHAR_I    = 8'h49;
    localparam byte_t CHAR_S    = 8'h53;
    localparam byte_t CHAR_P    = 8'h50;

    localparam int SP_LEN = 24;
    localparam logic [8*SP_LEN-1:0] SP_TEXT = "Never Gonna Give You Up!";

    typedef enum logic [1:0] {
        RESP_TX,
        RESP_FA,
        RESP_IF,
        RESP_SP
    } resp_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PARSE,
        ST_EMIT
    } eng_state_t;

    // what the line buffer shows the engine
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        byte_t              c0;
        byte_t              c1;
        byte_t              c2;
    } line_view_t;

    // one response word offered to the output register
    typedef struct packed {
        logic  valid;
        byte_t data;
        logic  last;
    } emit_t;

    function automatic logic is_digit(input byte_t ch);
        return (ch >= CHAR_0) && (ch <= CHAR_9);
    endfunction

    function automatic logic [POS_W-1:0] resp_last_pos(input resp_kind_t kind);
        logic [POS_W-1:0] p;
        case (kind)
            RESP_TX: p = 5'd3;
            RESP_FA: p = 5'd11;
            RESP_IF: p = 5'd27;
            RESP_SP: p = 5'd24;
            default: p = 5'd3;
        endcase
        return p;
    endfunction

    // digit 0 is the most significant one
    function automatic byte_t freq_char(input logic [FREQ_W-1:0] freq, input int k);
        return {4'h3, freq[4*(FREQ_DIGITS-1-k) +: 4]};
    endfunction

    function automatic byte_t resp_char(input resp_kind_t kind, input logic [POS_W-1:0] pos,
                                        input logic [FREQ_W-1:0] freq, input logic tx_en);
        byte_t ch;
        int    p;
        p  = int'(pos);
        ch = CHAR_0;
        case (kind)
            RESP_TX: begin
                case (pos)
                    5'd0:    ch = CHAR_T;
                    5'd1:    ch = CHAR_X;
                    5'd2:    ch = tx_en ? CHAR_1 : CHAR_0;
                    default: ch = CHAR_SEMI;
                endcase
            end
            RESP_FA: begin
                if (p == 0)
                    ch = CHAR_F;
                else if (p == 1)
                    ch = CHAR_A;
                else if (p < 2 + FREQ_DIGITS)
                    ch = freq_char(freq, p - 2);
                else if (p < 11)
                    ch = CHAR_0;
                else
                    ch = CHAR_SEMI;
            end
            RESP_IF: begin
                if (p == 0)
                    ch = CHAR_I;
                else if (p == 1)
                    ch = CHAR_F;
                else if (p < 5)
                    ch = CHAR_0;
                else if (p < 5 + FREQ_DIGITS)
                    ch = freq_char(freq, p - 5);
                else if (p < 27)
                    ch = CHAR_0;
                else
                    ch = CHAR_SEMI;
            end
            RESP_SP: begin
                if (p < SP_LEN)
                    ch = SP_TEXT[8*(SP_LEN-1-p) +: 8];
                else
                    ch = CHAR_SEMI;
            end
            default: ch = CHAR_SEMI;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/serial_radio_command_interpreter.sv =====
`timescale 1ns / 1ps
// top level of the serial radio command interpreter
// a plain character is counted into the line buffer when taken; ';' decodes in the cycle it is taken
// a response word offered by the sequencer is loaded into the output register and leaves from there,
// one word per cycle while out_ready holds
// a frequency set shifts its digits, at most six, into the frequency in the digit shifter
// reset: count and transmit enable clear, frequency 16000 khz, no response pending
module serial_radio_command_interpreter import rsci_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  byte_t rx_byte,
    output logic  out_valid,
    input  logic  out_ready,
    output byte_t tx_byte,
    output logic  last_of_response
);

    logic                  in_take;
    logic                  is_semi;
    logic                  eng_idle;
    line_view_t            view;
    byte_t                 rd_data;
    logic [LINE_IDX_W-1:0] rd_idx;
    emit_t                 emit;
    logic                  emit_take;

    logic  out_valid_reg, out_valid_next;
    byte_t tx_byte_reg, tx_byte_next;
    logic  last_reg, last_next;

    // input is taken whenever the sequencer is idle, even with a word still waiting
    assign in_ready = eng_idle;
    assign in_take  = in_valid && in_ready;
    assign is_semi  = (rx_byte == CHAR_SEMI);

    rsci_line_buf u_line_buf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (in_take && !is_semi),
        .clr     (in_take && is_semi),
        .wr_data (rx_byte),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .view    (view)
    );

    rsci_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .in_data   (rx_byte),
        .view      (view),
        .rd_data   (rd_data),
        .rd_idx    (rd_idx),
        .idle      (eng_idle),
        .emit      (emit),
        .emit_take (emit_take)
    );

    // output register: loads when empty or being drained this cycle
    assign emit_take = emit.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        if (emit_take)
        begin
            out_valid_next = 1'b1;
            tx_byte_next   = emit.data;
            last_next      = emit.last;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        tx_byte_reg <= tx_byte_next;
        last_reg    <= last_next;
    end

    assign out_valid        = out_valid_reg;
    assign tx_byte          = tx_byte_reg;
    assign last_of_response = last_reg;

endmodule

// ===== rtl/core/rsci_line_buf.sv =====
`timescale 1ns / 1ps
// line buffer: first eight characters of the line and a saturating count
module rsci_line_buf import rsci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  logic                  clr,
    input  byte_t                 wr_data,
    input  logic [LINE_IDX_W-1:0] rd_idx,
    output byte_t                 rd_data,
    output line_view_t            view
);

    byte_t              chars_reg [LINE_DEPTH];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (clr)
            count_next = '0;
        else if (wr && (count_reg < COUNT_MAX))
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // storage is undefined until written, only written slots are ever read
    always_ff @(posedge clk)
    begin
        if (wr && (count_reg < LINE_DEPTH_CNT))
            chars_reg[count_reg[LINE_IDX_W-1:0]] <= wr_data;
    end

    assign rd_data    = chars_reg[rd_idx];
    assign view.count = count_reg;
    assign view.c0    = chars_reg[0];
    assign view.c1    = chars_reg[1];
    assign view.c2    = chars_reg[2];

endmodule

// ===== rtl/core/rsci_engine.sv =====
`timescale 1ns / 1ps
// command sequencer: decode on ';', digit shift parse and response walk
module rsci_engine import rsci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_take,
    input  byte_t                 in_data,
    input  line_view_t            view,
    input  byte_t                 rd_data,
    output logic [LINE_IDX_W-1:0] rd_idx,
    output logic                  idle,
    output emit_t                 emit,
    input  logic                  emit_take
);

    eng_state_t         state_reg, state_next;
    resp_kind_t         kind_reg, kind_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] end_reg, end_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic               tx_en_reg, tx_en_next;
    logic [COUNT_W-1:0] stored;

    assign stored = (view.count > LINE_DEPTH_CNT) ? LINE_DEPTH_CNT : view.count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= RESP_TX;
            pos_reg   <= '0;
            idx_reg   <= '0;
            end_reg   <= '0;
            freq_reg  <= FREQ_RESET_BCD;
            tx_en_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
            freq_reg  <= freq_next;
            tx_en_reg <= tx_en_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        freq_next  = freq_reg;
        tx_en_next = tx_en_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (in_data == CHAR_SEMI) && (view.count >= MIN_CMD_LEN))
                begin
                    pos_next = '0;
                    if ((view.c0 == CHAR_T) && (view.c1 == CHAR_X))
                    begin
                        if (view.count == MIN_CMD_LEN)
                        begin
                            kind_next  = RESP_TX;
                            state_next = ST_EMIT;
                        end
                        else
                            tx_en_next = (view.c2 == CHAR_1);
                    end
                    else if ((view.c0 == CHAR_F) && (view.c1 == CHAR_A))
                    begin
                        if (view.count == MIN_CMD_LEN)
                        begin
                            kind_next  = RESP_FA;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            // no digits leaves zero
                            freq_next  = '0;
                            idx_next   = FIRST_ARG_POS;
                            end_next   = stored;
                            state_next = ST_PARSE;
                        end
                    end
                    else if ((view.c0 == CHAR_I) && (view.c1 == CHAR_F))
                    begin
                        kind_next  = RESP_IF;
                        state_next = ST_EMIT;
                    end
                    else if ((view.c0 == CHAR_S) && (view.c1 == CHAR_P))
                    begin
                        kind_next  = RESP_SP;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_PARSE:
            begin
                // one digit shifted in per cycle, stop at end of stored text or non-digit
                if ((idx_reg == end_reg) || !is_digit(rd_data))
                    state_next = ST_IDLE;
                else
                begin
                    freq_next = {freq_reg[FREQ_W-5:0], rd_data[3:0]};
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (emit_take)
                begin
                    if (pos_reg == resp_last_pos(kind_reg))
                        state_next = ST_IDLE;
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign rd_idx     = idx_reg[LINE_IDX_W-1:0];
    assign idle       = (state_reg == ST_IDLE);
    assign emit.valid = (state_reg == ST_EMIT);
    assign emit.data  = resp_char(kind_reg, pos_reg, freq_reg, tx_en_reg);
    assign emit.last  = (pos_reg == resp_last_pos(kind_reg));

endmodule

// ===== rtl/core/rsci_checker.sv =====
`timescale 1ns / 1ps
// port-level checker of the command interpreter and its bind
module rsci_checker import rsci_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input byte_t rx_byte,
    input logic  out_valid,
    input logic  out_ready,
    input byte_t tx_byte,
    input logic  last_of_response
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last_of_response))
        else $error("stalled response word changed");

    // mid-response no new input is taken
    a_busy_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_response |-> !in_ready)
        else $error("input ready in the middle of a response");

    // a plain character keeps the block ready
    a_plain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (rx_byte != CHAR_SEMI) |=> in_ready)
        else $error("ready dropped after a plain character");

    // a plain character never starts a response
    a_plain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (rx_byte != CHAR_SEMI) && !out_valid |=> !out_valid)
        else $error("response word after a plain character");

endmodule

bind serial_radio_command_interpreter rsci_checker u_rsci_checker (.*);
